/* sv/zdes_pkg.sv */
// shared types and constants for the z-drop extension scorer
package zdes_pkg;

  localparam int unsigned MAX_SEQ_LEN_DEF = 1048576;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic signed [31:0] PEAK_INIT = -32'sd1000000000;

  // alignment operation codes; OP_NONE marks "no previous operation"
  typedef enum logic [2:0] {
    OP_MATCH    = 3'd0,
    OP_INS      = 3'd1,
    OP_DEL      = 3'd2,
    OP_MISMATCH = 3'd3,
    OP_UNKNOWN  = 3'd4,
    OP_NONE     = 3'd7
  } op_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH       = 3'd0,
    REG_MISMATCH    = 3'd1,
    REG_GAP_OPEN    = 3'd2,
    REG_GAP_EXTEND  = 3'd3,
    REG_START_SCORE = 3'd4,
    REG_ZDROP       = 3'd5,
    REG_STOP_NEG    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [10:0] match_score;
    logic signed [10:0] mismatch_score;
    logic signed [10:0] gap_open_score;
    logic signed [10:0] gap_extend_score;
    logic [15:0]        start_score;
    logic signed [20:0] zdrop_limit;
    logic               stop_on_negative;
  } zdes_cfg_t;

  typedef struct packed {
    logic [2:0]  op_code;
    logic        first_op;
    logic        last_op;
    logic [20:0] query_length;
    logic [20:0] target_length;
  } zdes_in_t;

  typedef struct packed {
    logic [20:0]        stop_index;
    logic signed [31:0] final_score;
    logic [20:0]        query_pos;
    logic [20:0]        target_pos;
    logic signed [31:0] best_score;
    logic [20:0]        best_query_pos;
    logic [20:0]        best_target_pos;
    logic [21:0]        edit_distance;
    logic               unknown_op;
  } zdes_out_t;

endpackage

/* sv/zdes_cfg_regs.sv */
// configuration register file of the z-drop extension scorer
module zdes_cfg_regs import zdes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output zdes_cfg_t             cfg
);

  zdes_cfg_t cfg_r;
  zdes_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH:       cfg_nxt.match_score      = cfg_wdata[10:0];
        REG_MISMATCH:    cfg_nxt.mismatch_score   = cfg_wdata[10:0];
        REG_GAP_OPEN:    cfg_nxt.gap_open_score   = cfg_wdata[10:0];
        REG_GAP_EXTEND:  cfg_nxt.gap_extend_score = cfg_wdata[10:0];
        REG_START_SCORE: cfg_nxt.start_score      = cfg_wdata[15:0];
        REG_ZDROP:       cfg_nxt.zdrop_limit      = cfg_wdata[20:0];
        REG_STOP_NEG:    cfg_nxt.stop_on_negative = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_score      <= 11'sd1;
      cfg_r.mismatch_score   <= -11'sd1;
      cfg_r.gap_open_score   <= -11'sd1;
      cfg_r.gap_extend_score <= -11'sd1;
      cfg_r.start_score      <= '0;
      cfg_r.zdrop_limit      <= -21'sd1;
      cfg_r.stop_on_negative <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/zdes_in_stage.sv */
// input register stage of the z-drop extension scorer
module zdes_in_stage import zdes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  zdes_in_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output zdes_in_t item
);

  logic     valid_r;
  logic     valid_nxt;
  zdes_in_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* sv/zdes_core.sv */
// extension state and combinational scoring of one alignment operation
module zdes_core import zdes_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  zdes_in_t  item,
  input  zdes_cfg_t cfg,
  output logic      res_valid,
  output zdes_out_t res
);

  localparam logic [31:0]        MaxLenFull = 32'(MAX_SEQ_LEN);
  localparam logic [20:0]        MaxLen     = MaxLenFull[20:0];
  localparam logic signed [33:0] ScoreMax   = 34'sd2147483647;
  localparam logic signed [33:0] ScoreMin   = -34'sd2147483648;

  logic signed [31:0] run_score_r, peak_score_r;
  logic [20:0]        peak_qpos_r, peak_tpos_r, cur_qpos_r, cur_tpos_r;
  logic [21:0]        edits_r, op_index_r;
  logic [2:0]         prev_code_r;
  logic               halted_r;

  logic signed [31:0] base_run, base_peak;
  logic [20:0]        base_pq, base_pt, base_q, base_t;
  logic [21:0]        base_edits, base_idx;
  logic [2:0]         base_prev;
  logic               base_halted;

  logic signed [31:0] run_score_nxt, peak_score_nxt;
  logic [20:0]        peak_qpos_nxt, peak_tpos_nxt, cur_qpos_nxt, cur_tpos_nxt;
  logic [21:0]        edits_nxt, op_index_nxt;
  logic [2:0]         prev_code_nxt;
  logic               halted_nxt;

  logic [20:0]        qlen, tlen;
  logic signed [10:0] add_a, add_b;
  logic               inc_q, inc_t, inc_e, unknown;
  logic signed [33:0] sc, zd_thresh;
  logic signed [31:0] run_n, peak_n;
  logic [20:0]        pq_n, pt_n, q_n, t_n;
  logic signed [20:0] zd;
  logic               zstop, stop;

  always_comb begin
    // a first operation restarts the extension before it is scored
    if (item.first_op) begin
      base_run    = 32'(signed'({1'b0, cfg.start_score}));
      base_peak   = PEAK_INIT;
      base_pq     = '0;
      base_pt     = '0;
      base_q      = '0;
      base_t      = '0;
      base_edits  = '0;
      base_prev   = OP_NONE;
      base_idx    = '0;
      base_halted = 1'b0;
    end else begin
      base_run    = run_score_r;
      base_peak   = peak_score_r;
      base_pq     = peak_qpos_r;
      base_pt     = peak_tpos_r;
      base_q      = cur_qpos_r;
      base_t      = cur_tpos_r;
      base_edits  = edits_r;
      base_prev   = prev_code_r;
      base_idx    = op_index_r;
      base_halted = halted_r;
    end

    qlen = (32'(item.query_length) > MaxLenFull) ? MaxLen : item.query_length;
    tlen = (32'(item.target_length) > MaxLenFull) ? MaxLen : item.target_length;

    add_a   = '0;
    add_b   = '0;
    inc_q   = 1'b0;
    inc_t   = 1'b0;
    inc_e   = 1'b0;
    unknown = 1'b0;
    case (item.op_code) inside
      OP_MATCH: begin
        add_a = cfg.match_score;
        inc_q = 1'b1;
        inc_t = 1'b1;
      end
      OP_MISMATCH: begin
        add_a = cfg.mismatch_score;
        inc_q = 1'b1;
        inc_t = 1'b1;
        inc_e = 1'b1;
      end
      OP_INS, OP_DEL: begin
        // gap open only when the run of codes changes
        if (item.op_code != base_prev) begin
          add_a = cfg.gap_open_score;
        end
        add_b = cfg.gap_extend_score;
        inc_q = (item.op_code == OP_INS);
        inc_t = (item.op_code == OP_DEL);
        inc_e = 1'b1;
      end
      default: unknown = 1'b1;
    endcase

    sc = 34'(base_run) + 34'(add_a) + 34'(add_b);
    if (sc > ScoreMax) begin
      run_n = 32'sh7FFF_FFFF;
    end else if (sc < ScoreMin) begin
      run_n = -32'sh8000_0000;
    end else begin
      run_n = sc[31:0];
    end

    q_n = base_q + 21'(inc_q);
    t_n = base_t + 21'(inc_t);

    if (!unknown && (run_n > base_peak)) begin
      peak_n = run_n;
      pq_n   = q_n;
      pt_n   = t_n;
    end else begin
      peak_n = base_peak;
      pq_n   = base_pq;
      pt_n   = base_pt;
    end

    // negative limit turns the drop check off
    zd        = cfg.zdrop_limit;
    zd_thresh = 34'(peak_n) - 34'(zd);
    zstop     = !zd[20] && (34'(run_n) < zd_thresh);

    stop = unknown || (q_n >= qlen) || (t_n >= tlen)
        || (cfg.stop_on_negative && run_n[31]) || zstop;

    res_valid = step && !base_halted && (stop || item.last_op);

    res.stop_index    = base_idx[21] ? '1 : base_idx[20:0];
    res.edit_distance = base_edits + 22'(inc_e);
    res.unknown_op    = unknown;
    if (unknown) begin
      res.final_score     = '0;
      res.query_pos       = qlen;
      res.target_pos      = tlen;
      res.best_score      = '0;
      res.best_query_pos  = qlen;
      res.best_target_pos = tlen;
    end else begin
      res.final_score     = run_n;
      res.query_pos       = q_n;
      res.target_pos      = t_n;
      res.best_score      = peak_n;
      res.best_query_pos  = pq_n;
      res.best_target_pos = pt_n;
    end

    // a halted extension only takes the restart, if any
    if (base_halted) begin
      run_score_nxt  = base_run;
      peak_score_nxt = base_peak;
      peak_qpos_nxt  = base_pq;
      peak_tpos_nxt  = base_pt;
      cur_qpos_nxt   = base_q;
      cur_tpos_nxt   = base_t;
      edits_nxt      = base_edits;
      prev_code_nxt  = base_prev;
      op_index_nxt   = base_idx;
      halted_nxt     = base_halted;
    end else begin
      run_score_nxt  = run_n;
      peak_score_nxt = peak_n;
      peak_qpos_nxt  = pq_n;
      peak_tpos_nxt  = pt_n;
      cur_qpos_nxt   = q_n;
      cur_tpos_nxt   = t_n;
      edits_nxt      = res.edit_distance;
      prev_code_nxt  = item.op_code;
      op_index_nxt   = (&base_idx) ? base_idx : base_idx + 22'd1;
      halted_nxt     = stop || item.last_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_score_r  <= '0;
      peak_score_r <= PEAK_INIT;
      peak_qpos_r  <= '0;
      peak_tpos_r  <= '0;
      cur_qpos_r   <= '0;
      cur_tpos_r   <= '0;
      edits_r      <= '0;
      prev_code_r  <= OP_NONE;
      op_index_r   <= '0;
      halted_r     <= 1'b0;
    end else if (step) begin
      run_score_r  <= run_score_nxt;
      peak_score_r <= peak_score_nxt;
      peak_qpos_r  <= peak_qpos_nxt;
      peak_tpos_r  <= peak_tpos_nxt;
      cur_qpos_r   <= cur_qpos_nxt;
      cur_tpos_r   <= cur_tpos_nxt;
      edits_r      <= edits_nxt;
      prev_code_r  <= prev_code_nxt;
      op_index_r   <= op_index_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

/* sv/zdrop_extension_scorer_unit.sv */
// top level of the z-drop extension scorer: input stage, scoring core, result register
// a request goes from the input register through the core; any result lands in the result register
// throughput: one request per cycle unless a result stalls; the next extension state is formed
//   combinationally inside the scoring core, so consecutive operations chain without bubbles
// the result register stalls the core only while a result waits on out_ready
// reset: synchronous active-low rst_n clears the channels, the extension state and
//   returns the configuration registers to their defaults; no clearing pass
module zdrop_extension_scorer_unit import zdes_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  zdes_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output zdes_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  zdes_cfg_t cfg;
  zdes_in_t  item;
  zdes_out_t res;
  logic      item_valid;
  logic      advance;
  logic      step;
  logic      res_valid;

  logic      out_valid_r;
  logic      out_valid_nxt;
  zdes_out_t out_data_r;

  // configuration registers, to be written only while idle; the block itself does not enforce this
  zdes_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register: accepts a new request whenever the core moves on
  zdes_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // core moves when the result register is empty or being drained
  assign advance = !out_valid_r || out_ready;
  assign step    = item_valid && advance;

  // scoring core: state registers plus combinational add, clamp and compares
  zdes_core #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_comb begin
    if (step && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stalled result must freeze the core
  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !step)
    else $error("core stepped while a result was stalled");

  // input stage only pushes back when it holds a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_valid)
    else $error("input stage refused a request while empty");

  // an unknown stop reports zero scores
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.unknown_op) |->
      (out_data_r.final_score == 32'sd0 && out_data_r.best_score == 32'sd0))
    else $error("unknown stop with nonzero scores");

  // best score never below the final score on a scored stop
  a_best_ge_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.unknown_op) |->
      (out_data_r.best_score >= out_data_r.final_score))
    else $error("best score below final score");

endmodule
